@@ src/stream_find_replace_core_assert.svh @@
// Assertion helpers shared by the find/replace RTL.
`ifndef STREAM_FIND_REPLACE_CORE_ASSERT_SVH
`define STREAM_FIND_REPLACE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sfr_pkg.sv @@
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int MAX_RESULTS     = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                     MAX_PATTERN : MAX_REPLACEMENT;

    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam int PAT_W = 8 * MAX_PATTERN;
    localparam int REP_W = 8 * MAX_REPLACEMENT;
    localparam int CFG_DATA_W = (PAT_W > REP_W) ? PAT_W : REP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;

    // Output queue: room for two full bursts.
    localparam int OQ_DEPTH = 2 * MAX_RESULTS;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       text_done;
    } t_out;

    // Results caused by one accepted word.
    typedef struct packed {
        logic [CNT_W-1:0]             n;
        t_out [MAX_RESULTS-1:0]       item;
    } t_burst;

    // Per-cell control from the window controller.
    typedef struct packed {
        logic load;
        logic ins;
        logic shift;
    } t_cell_ctl;

    // A length of zero counts as one; lengths above the maximum saturate.
    function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] raw,
                                                   input logic [CNT_W-1:0] max_len);
        logic [CNT_W-1:0] res;
        if (raw == '0) begin
            res = CNT_W'(1);
        end else if (CNT_W'(raw) > max_len) begin
            res = max_len;
        end else begin
            res = CNT_W'(raw);
        end
        return res;
    endfunction

endpackage

@@ src/stream_find_replace_core.sv @@
// Streaming find-and-replace over a byte text.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one text byte per
// word; end_of_text marks the last byte. Output channel (o_out_valid /
// i_out_ready / o_out_word) gives the rewritten text one byte per word, with
// last_of_run on the final byte caused by an input word and text_done on the
// final byte of the text. Pattern and replacement (up to 8 bytes each) are set
// through the write port (i_cfg_we / i_cfg_idx / i_cfg_data); the user sets
// them only while idle, which the block does not enforce. Writing the pattern
// length drops any held bytes. The window is a row of eight byte cells, each
// comparing its byte with one pattern byte, so one input word is taken per
// cycle while the output queue has room. A word's results enter a 16-entry
// output queue and leave one per cycle while the receiver is ready, so plain
// pass-through runs at one byte per cycle, and the input stalls only once
// more than 8 bytes wait in the queue. When the receiver stalls, queued bytes
// stay put and input keeps flowing until the queue is more than half full.
// Reset empties the window and the queue and sets pattern and replacement to
// one zero byte.
`include "stream_find_replace_core_assert.svh"

module stream_find_replace_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sfr_pkg::t_in                       i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sfr_pkg::t_out                      o_out_word,
    input  logic                               i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sfr_pkg::*;

    logic [PAT_W-1:0] r_pat;
    logic [LEN_W-1:0] r_plen;
    logic [REP_W-1:0] r_rep;
    logic [LEN_W-1:0] r_rlen;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic             accept;
    logic             eot;
    logic [CNT_W-1:0] plen;
    logic [CNT_W-1:0] rlen;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] new_cnt;
    logic             full;
    logic             all_eq;
    logic             match;
    logic             shift;
    t_burst           burst;

    logic [7:0]       cur  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq;
    t_cell_ctl        ctl  [MAX_PATTERN];

    assign accept = i_in_valid && o_in_ready;
    assign eot    = i_in_word.end_of_text;
    assign plen   = clamp_len(r_plen, CNT_W'(MAX_PATTERN));
    assign rlen   = clamp_len(r_rlen, CNT_W'(MAX_REPLACEMENT));

    always_comb begin
        cnt_eff = (r_cnt >= plen) ? '0 : r_cnt;
        new_cnt = cnt_eff + CNT_W'(1);
        full    = (new_cnt == plen);
        all_eq  = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) < plen && !eq[i]) begin
                all_eq = 1'b0;
            end
        end
        match = full && all_eq;
        // A full window without a match drops its oldest byte.
        shift = full && !match && !eot;
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            ctl[i].load  = accept;
            ctl[i].ins   = (CNT_W'(i) == cnt_eff);
            ctl[i].shift = shift;
        end
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl[g]),
            .i_in_byte   (i_in_word.in_byte),
            .i_next_byte (cur[(g + 1 < MAX_PATTERN) ? g + 1 : g]),
            .i_pat_byte  (r_pat[g*8 +: 8]),
            .o_cur_byte  (cur[g]),
            .o_eq        (eq[g])
        );
    end

    // On a match the burst is the replacement; otherwise it is the window
    // from its oldest byte: one byte when full, all on end of text, else none.
    always_comb begin
        if (match) begin
            burst.n = rlen;
        end else if (eot) begin
            burst.n = new_cnt;
        end else if (full) begin
            burst.n = CNT_W'(1);
        end else begin
            burst.n = '0;
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            burst.item[k].out_byte    = match ? r_rep[(k % MAX_REPLACEMENT)*8 +: 8]
                                              : cur[k % MAX_PATTERN];
            burst.item[k].last_of_run = (CNT_W'(k + 1) == burst.n);
            burst.item[k].text_done   = (CNT_W'(k + 1) == burst.n) && eot;
        end
    end

    always_comb begin
        if (match || eot) begin
            n_cnt = '0;
        end else if (full) begin
            n_cnt = plen - CNT_W'(1);
        end else begin
            n_cnt = new_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= LEN_W'(1);
            r_rep  <= '0;
            r_rlen <= LEN_W'(1);
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_cnt <= n_cnt;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PATTERN_BYTES: begin
                        r_pat <= i_cfg_data[PAT_W-1:0];
                    end
                    CFG_PATTERN_LENGTH: begin
                        r_plen <= i_cfg_data[LEN_W-1:0];
                        r_cnt  <= '0;
                    end
                    CFG_REPLACEMENT_BYTES: begin
                        r_rep <= i_cfg_data[REP_W-1:0];
                    end
                    CFG_REPLACEMENT_LENGTH: begin
                        r_rlen <= i_cfg_data[LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    sfr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_burst (burst),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    `SFR_ASSERT_NOW(a_cnt_below_len, i_clk, i_rst_n, 1'b1, r_cnt < plen,
        "window holds a whole pattern length")
    `SFR_ASSERT_NEXT(a_match_empties, i_clk, i_rst_n, accept && match, r_cnt == '0,
        "window not empty after a match")
    `SFR_ASSERT_NEXT(a_eot_empties, i_clk, i_rst_n, accept && eot, r_cnt == '0,
        "window not empty after end of text")
    `SFR_ASSERT_NEXT(a_burst_shows, i_clk, i_rst_n, accept && burst.n != '0, o_out_valid,
        "result of an accepted word not offered")

endmodule

@@ src/sfr_cell.sv @@
module sfr_cell (
    input  logic              i_clk,
    input  sfr_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]        i_in_byte,
    input  logic [7:0]        i_next_byte,
    input  logic [7:0]        i_pat_byte,
    output logic [7:0]        o_cur_byte,
    output logic              o_eq
);
    import sfr_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // The incoming byte lands in the cell that sits at the fill position.
    assign o_cur_byte = i_ctl.ins ? i_in_byte : r_byte;
    assign o_eq       = (o_cur_byte == i_pat_byte);

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.load) begin
            n_byte = i_ctl.shift ? i_next_byte : o_cur_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

@@ src/sfr_outq.sv @@
`include "stream_find_replace_core_assert.svh"

module sfr_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfr_pkg::t_burst i_burst,
    output logic            o_space,
    output logic            o_valid,
    input  logic            i_ready,
    output sfr_pkg::t_out   o_word
);
    import sfr_pkg::*;

    t_out                r_slot [OQ_DEPTH];
    t_out                n_slot [OQ_DEPTH];
    logic [OQ_CNT_W-1:0] r_cnt;
    logic [OQ_CNT_W-1:0] n_cnt;
    logic                pop;
    logic [OQ_CNT_W-1:0] base;
    logic [OQ_CNT_W-1:0] push_n;
    logic [OQ_CNT_W-1:0] off;

    assign o_valid = (r_cnt != '0);
    assign o_word  = r_slot[0];
    assign o_space = (r_cnt <= OQ_CNT_W'(OQ_DEPTH - MAX_RESULTS));
    assign pop     = o_valid && i_ready;
    assign base    = r_cnt - OQ_CNT_W'(pop);
    assign push_n  = i_push ? OQ_CNT_W'(i_burst.n) : '0;
    assign n_cnt   = base + push_n;

    // Held words move one slot toward the head on a pop; a new burst is
    // appended right behind the last word that stays.
    always_comb begin
        off = '0;
        for (int j = 0; j < OQ_DEPTH; j++) begin
            off = OQ_CNT_W'(j) - base;
            if (OQ_CNT_W'(j) < base) begin
                n_slot[j] = pop ? r_slot[(j + 1) % OQ_DEPTH] : r_slot[j];
            end else if (off < push_n) begin
                n_slot[j] = i_burst.item[off[RES_IDX_W-1:0]];
            end else begin
                n_slot[j] = r_slot[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < OQ_DEPTH; j++) begin
            r_slot[j] <= n_slot[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `SFR_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && !i_push,
        r_cnt == $past(r_cnt) - OQ_CNT_W'(1), "output queue count wrong after pop")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sfr_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE       = 24;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 32;

    // Mirrors the window and the registers, and holds the bytes still owed by the block.
    class rewrite_tracker;
        logic [63:0] pattern;
        logic [63:0] replacement;
        logic [3:0]  pat_len_raw;
        logic [3:0]  rep_len_raw;
        logic [7:0]  window [MAX_PATTERN];
        int          held;
        t_out        owed_bytes [$];
        int          errors;

        function new();
            pattern     = '0;
            replacement = '0;
            pat_len_raw = 4'd1;
            rep_len_raw = 4'd1;
            foreach (window[k]) window[k] = '0;
            held   = 0;
            errors = 0;
        endfunction

        function int effective_len(logic [3:0] raw, int max_len);
            if (raw == 4'd0) return 1;
            if (int'(raw) > max_len) return max_len;
            return int'(raw);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN_BYTES: pattern = data[63:0];
                CFG_PATTERN_LENGTH: begin
                    pat_len_raw = data[3:0];
                    held = 0;
                end
                CFG_REPLACEMENT_BYTES: replacement = data[63:0];
                CFG_REPLACEMENT_LENGTH: rep_len_raw = data[3:0];
                default: ;
            endcase
        endfunction

        function void take_word(t_in w);
            int   plen;
            int   rlen;
            bit   hit;
            t_out run [$];
            t_out r;
            plen = effective_len(pat_len_raw, MAX_PATTERN);
            rlen = effective_len(rep_len_raw, MAX_REPLACEMENT);
            r.last_of_run = 1'b0;
            r.text_done   = 1'b0;
            if (held >= plen) held = 0;
            window[held] = w.in_byte;
            held++;
            if (held == plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++) begin
                    if (window[i] != pattern[8*i +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    for (int i = 0; i < rlen; i++) begin
                        r.out_byte = replacement[8*i +: 8];
                        run.push_back(r);
                    end
                    held = 0;
                end else begin
                    r.out_byte = window[0];
                    run.push_back(r);
                    for (int i = 1; i < held; i++) window[i-1] = window[i];
                    held--;
                end
            end
            if (w.end_of_text) begin
                for (int i = 0; i < held; i++) begin
                    r.out_byte = window[i];
                    run.push_back(r);
                end
                held = 0;
            end
            if (run.size() > 0) begin
                run[run.size()-1].last_of_run = 1'b1;
                if (w.end_of_text) run[run.size()-1].text_done = 1'b1;
            end
            foreach (run[k]) owed_bytes.push_back(run[k]);
        endfunction

        function void check_word(t_out got);
            t_out want;
            if (owed_bytes.size() == 0) begin
                $error("word with nothing expected: out_byte %h last_of_run %b text_done %b",
                       got.out_byte, got.last_of_run, got.text_done);
                errors++;
                return;
            end
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %b, actual %b", want.last_of_run, got.last_of_run);
                errors++;
            end
            if (got.text_done !== want.text_done) begin
                $error("text_done: expected %b, actual %b", want.text_done, got.text_done);
                errors++;
            end
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rewrite_tracker tracker;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             quiet_cycles;
    logic [63:0]    cur_pat;
    int             cur_plen;

    stream_find_replace_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.write_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && o_in_ready) tracker.take_word(i_in_word);
            if (o_out_valid && i_out_ready) tracker.check_word(o_out_word);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eot);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= t_in'{in_byte: b, end_of_text: eot};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stops sending and lets every owed byte come out, plus the window's settling time.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] rep, input logic [3:0] rlen,
                             input bit write_lengths, input bit poke_spare);
        logic [CFG_DATA_W-1:0] len_data;
        wait_idle();
        put_reg(CFG_PATTERN_BYTES, pat);
        put_reg(CFG_REPLACEMENT_BYTES, rep);
        if (write_lengths) begin
            // Bits above the length field carry noise now and then; only the low nibble counts.
            len_data = ($urandom_range(1) == 0) ? '0 : {$urandom, $urandom};
            len_data[3:0] = plen;
            put_reg(CFG_PATTERN_LENGTH, len_data);
            len_data = ($urandom_range(1) == 0) ? '0 : {$urandom, $urandom};
            len_data[3:0] = rlen;
            put_reg(CFG_REPLACEMENT_LENGTH, len_data);
            cur_plen = tracker.effective_len(plen, MAX_PATTERN);
        end
        if (poke_spare) begin
            put_reg(CFG_IDX_W'($urandom_range(int'(CFG_REPLACEMENT_LENGTH) + 1,
                                              (1 << CFG_IDX_W) - 1)),
                    {$urandom, $urandom});
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_pat = pat;
    endtask

    function automatic logic [63:0] draw_text_bytes(input bit wide);
        logic [63:0] v;
        for (int k = 0; k < 8; k++) begin
            v[8*k +: 8] = wide ? 8'($urandom_range(255)) : 8'(8'h61 + $urandom_range(3));
        end
        return v;
    endfunction

    // Texts built mostly from whole and partial pattern copies over a small alphabet,
    // so matches, near misses and overlaps are common.
    task automatic run_texts(input int n_items);
        int          sent;
        int          len;
        int          pick;
        int          cut;
        bit          finish;
        logic [7:0]  text [$];
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 16);
            if (len > n_items - sent) len = n_items - sent;
            text.delete();
            while (text.size() < len) begin
                pick = $urandom_range(9);
                if (pick < 4) begin
                    for (int k = 0; k < cur_plen; k++) text.push_back(cur_pat[8*k +: 8]);
                end else if (pick < 6) begin
                    cut = $urandom_range(1, cur_plen);
                    for (int k = 0; k < cut; k++) text.push_back(cur_pat[8*k +: 8]);
                end else if (pick < 9) begin
                    text.push_back(8'(8'h61 + $urandom_range(3)));
                end else begin
                    text.push_back(8'($urandom_range(255)));
                end
            end
            while (text.size() > len) void'(text.pop_back());
            // The last text of a phase is left open half the time, so the next
            // register writes land on a window that still holds bytes.
            finish = (sent + len < n_items) ? ($urandom_range(19) != 0) : ($urandom_range(1) == 0);
            for (int k = 0; k < len; k++) send_word(text[k], finish && (k == len - 1));
            sent += len;
        end
    endtask

    initial begin
        logic [3:0]  plen;
        logic [3:0]  rlen;
        int          pick;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_word     = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_PATTERN_BYTES;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles  = 0;
        cur_pat       = '0;
        cur_plen      = 1;
        tracker       = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one zero byte replaced by one zero byte.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);

        // Three-byte pattern, widest replacement of all ones, text ending on a partial match.
        configure(64'h0000_0000_0063_6261, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0);
        send_word(8'h78, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b0);
        send_word(8'h63, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b1);

        // Zero pattern length acts as one, oversized replacement length saturates.
        configure(64'h0000_0000_0000_00FF, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);

        // Full-width pattern matched on the final byte, zero replacement length,
        // and a write to an index past the last register.
        configure({8{8'hA5}}, 4'd8, {8{8'h5A}}, 4'd0, 1'b1, 1'b1);
        for (int k = 0; k < 8; k++) send_word(8'hA5, k == 7);

        // Pattern bytes change while the window holds bytes; the held bytes stay.
        for (int k = 0; k < 3; k++) send_word(8'hA5, 1'b0);
        configure(64'h0000_0000_0000_0000, 4'd8, {8{8'h5A}}, 4'd0, 1'b0, 1'b0);
        for (int k = 0; k < 5; k++) send_word(8'hA5, k == 4);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 12 : ((mode == 1) ? 47 : 0);
            recv_idle_pct = (mode == 0) ? 47 : ((mode == 1) ? 12 : 0);
            for (int c = 0; c < 4; c++) begin
                pick = $urandom_range(9);
                plen = (pick == 0) ? 4'd0 :
                       ((pick == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8)));
                pick = $urandom_range(9);
                rlen = (pick == 0) ? 4'd0 :
                       ((pick == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8)));
                if (c == 0) begin
                    plen = (mode == 1) ? 4'd8 : 4'd1;
                    rlen = (mode == 1) ? 4'd1 : 4'd8;
                end
                configure(draw_text_bytes($urandom_range(3) == 0), plen,
                          draw_text_bytes($urandom_range(1) == 0), rlen,
                          c != 2, $urandom_range(3) == 0);
                run_texts(PHASE_ITEMS);
            end
        end

        wait_idle();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
